// File: sv/hvd_pkg.sv
package hvd_pkg;

  localparam int DEG_W            = 25;
  localparam int DIST_W           = 23;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_DEF   = 16;
  localparam int DW               = 34;
  localparam int SQ_W             = 62;
  localparam int SQRT_STEPS       = 31;
  localparam int ROOT_W           = 31;

  typedef logic signed [DW-1:0]    cval_t;
  typedef logic signed [DEG_W-1:0] deg_t;
  typedef logic signed [DEG_W:0]   ddeg_t;

  localparam logic [31:0] PI_Q30       = 32'd3373259425;
  localparam cval_t       CORDIC_K     = cval_t'(652032874);
  localparam cval_t       HALF_PI_Q30  = cval_t'(1686629713);
  localparam cval_t       ONE_Q30      = cval_t'(1073741824);
  localparam deg_t        DEG_LIMIT    = deg_t'(11796480);
  localparam logic [13:0] EARTH_DIAM   = 14'd12742;
  localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(5124000);

  function automatic deg_t sat_deg(input deg_t v);
    deg_t r;
    if (v > DEG_LIMIT) begin
      r = DEG_LIMIT;
    end else if (v < -DEG_LIMIT) begin
      r = -DEG_LIMIT;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic cval_t atan_q30(input logic [4:0] idx);
    cval_t r;
    case (idx)
      5'd0:  r = cval_t'(32'h3243F6A8);
      5'd1:  r = cval_t'(32'h1DAC6705);
      5'd2:  r = cval_t'(32'h0FADBAFC);
      5'd3:  r = cval_t'(32'h07F56EA6);
      5'd4:  r = cval_t'(32'h03FEAB76);
      5'd5:  r = cval_t'(32'h01FFD55B);
      5'd6:  r = cval_t'(32'h00FFFAAA);
      5'd7:  r = cval_t'(32'h007FFF55);
      5'd8:  r = cval_t'(32'h003FFFEA);
      5'd9:  r = cval_t'(32'h001FFFFD);
      5'd10: r = cval_t'(32'h000FFFFF);
      5'd11: r = cval_t'(32'h0007FFFF);
      5'd12: r = cval_t'(32'h0003FFFF);
      5'd13: r = cval_t'(32'h0001FFFF);
      5'd14: r = cval_t'(32'h0000FFFF);
      5'd15: r = cval_t'(32'h00007FFF);
      5'd16: r = cval_t'(32'h00003FFF);
      5'd17: r = cval_t'(32'h00001FFF);
      5'd18: r = cval_t'(32'h00000FFF);
      5'd19: r = cval_t'(32'h000007FF);
      5'd20: r = cval_t'(32'h000003FF);
      5'd21: r = cval_t'(32'h000001FF);
      5'd22: r = cval_t'(32'h000000FF);
      5'd23: r = cval_t'(32'h0000007F);
      5'd24: r = cval_t'(32'h0000003F);
      5'd25: r = cval_t'(32'h0000001F);
      5'd26: r = cval_t'(32'h0000000F);
      5'd27: r = cval_t'(32'h00000007);
      5'd28: r = cval_t'(32'h00000003);
      5'd29: r = cval_t'(32'h00000001);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/haversine_distance.sv
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while a finished result waits on out_ready.
// Reset: synchronous, active low; clears the valid bits of every stage, so no
// result is presented after reset. Datapath registers are not reset.
module haversine_distance #(
  parameter int CORDIC_STEPS    = hvd_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = hvd_pkg::ANGLE_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  hvd_pkg::deg_t              in_from_lat,
  input  hvd_pkg::deg_t              in_from_lon,
  input  hvd_pkg::deg_t              in_to_lat,
  input  hvd_pkg::deg_t              in_to_lon,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hvd_pkg::DIST_W-1:0] out_distance_km
);
  import hvd_pkg::*;

  localparam int LAT = 2 * CORDIC_STEPS + 39;

  logic [LAT-1:0]    vld_r;
  logic              en;
  ddeg_t             dlat_r, dlon_r, lat1_r, lat2_r;
  cval_t             z0, z1, z2, z3;
  logic              f0, f1, f2, f3;
  cval_t             s1, s2, c1, c2, cd0, cd1, sd2, sd3;
  logic signed [2*DW-1:0] m1, m2, m3, m4;
  cval_t             p1_r, p2_r, p3_r, q1_r, p4_r;
  cval_t             asum;
  logic [ROOT_W-1:0] a_c;
  logic [SQ_W-1:0]   sqa_r, sqb_r;
  logic [ROOT_W-1:0] ra, rb;
  cval_t             zv;
  logic [ROOT_W-1:0] zc;
  logic [45:0]       dsum;
  logic [DIST_W-1:0] dist_r;

  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dlat_r <= ddeg_t'(sat_deg(in_to_lat)) - ddeg_t'(sat_deg(in_from_lat));
      dlon_r <= ddeg_t'(sat_deg(in_to_lon)) - ddeg_t'(sat_deg(in_from_lon));
      lat1_r <= ddeg_t'(sat_deg(in_from_lat));
      lat2_r <= ddeg_t'(sat_deg(in_to_lat));
    end
  end

  hvd_rad #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .DIV_SHIFT(3)) u_rad0 (
    .clk(clk), .en(en), .deg_in(dlat_r), .z_out(z0), .flip_out(f0));
  hvd_rad #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .DIV_SHIFT(3)) u_rad1 (
    .clk(clk), .en(en), .deg_in(dlon_r), .z_out(z1), .flip_out(f1));
  hvd_rad #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .DIV_SHIFT(2)) u_rad2 (
    .clk(clk), .en(en), .deg_in(lat1_r), .z_out(z2), .flip_out(f2));
  hvd_rad #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .DIV_SHIFT(2)) u_rad3 (
    .clk(clk), .en(en), .deg_in(lat2_r), .z_out(z3), .flip_out(f3));

  hvd_rot #(.STEPS(CORDIC_STEPS)) u_rot0 (
    .clk(clk), .en(en), .z_in(z0), .flip_in(f0), .sin_out(s1), .cos_out(cd0));
  hvd_rot #(.STEPS(CORDIC_STEPS)) u_rot1 (
    .clk(clk), .en(en), .z_in(z1), .flip_in(f1), .sin_out(s2), .cos_out(cd1));
  hvd_rot #(.STEPS(CORDIC_STEPS)) u_rot2 (
    .clk(clk), .en(en), .z_in(z2), .flip_in(f2), .sin_out(sd2), .cos_out(c1));
  hvd_rot #(.STEPS(CORDIC_STEPS)) u_rot3 (
    .clk(clk), .en(en), .z_in(z3), .flip_in(f3), .sin_out(sd3), .cos_out(c2));

  // Only the sines of the half differences and the cosines of the latitudes matter.
  always_comb begin
    m1 = s1 * s1;
    m2 = s2 * s2;
    m3 = c1 * c2;
    m4 = p2_r * p3_r;
    asum = q1_r + p4_r;
    if (asum < 0) begin
      a_c = '0;
    end else if (asum > ONE_Q30) begin
      a_c = ROOT_W'(ONE_Q30);
    end else begin
      a_c = ROOT_W'(asum);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= m1[30 +: DW];
      p2_r  <= m2[30 +: DW];
      p3_r  <= m3[30 +: DW];
      q1_r  <= p1_r;
      p4_r  <= m4[30 +: DW];
      sqa_r <= {a_c, 31'b0} >> 1;
      sqb_r <= {ROOT_W'(ONE_Q30) - a_c, 31'b0} >> 1;
    end
  end

  hvd_isqrt u_sqa (.clk(clk), .en(en), .v_in(sqa_r), .root_out(ra));
  hvd_isqrt u_sqb (.clk(clk), .en(en), .v_in(sqb_r), .root_out(rb));

  hvd_vec #(.STEPS(CORDIC_STEPS)) u_vec (
    .clk(clk), .en(en), .x_in(cval_t'(rb)), .y_in(cval_t'(ra)), .z_out(zv));

  always_comb begin
    if (zv < 0) begin
      zc = '0;
    end else if (zv > HALF_PI_Q30) begin
      zc = ROOT_W'(HALF_PI_Q30);
    end else begin
      zc = ROOT_W'(zv);
    end
    dsum = 46'(zc) * 46'(EARTH_DIAM) + (46'(1) << 21);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dsum[22 +: DIST_W];
    end
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_distance_km = dist_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r)) else $error("valid pipeline moved during a stall");
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0]) else $error("accepted request lost");
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance_km <= MAX_DIST) else $error("distance out of range");
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0) else $error("valid bits not cleared by reset");

endmodule

// File: sv/hvd_rad.sv
module hvd_rad #(
  parameter int ANGLE_FRAC_BITS = hvd_pkg::ANGLE_FRAC_DEF,
  parameter int DIV_SHIFT       = 3
) (
  input  logic          clk,
  input  logic          en,
  input  hvd_pkg::ddeg_t deg_in,
  output hvd_pkg::cval_t z_out,
  output logic          flip_out
);
  import hvd_pkg::*;

  localparam int PW = 58;
  localparam int K  = 46 - ANGLE_FRAC_BITS + DIV_SHIFT;
  localparam int NW = PW - K;
  localparam int S  = NW + 6;
  localparam int MW = S - 5;
  localparam int QW = NW - 5;
  localparam int AW = QW + 1;
  localparam logic [PW-1:0] HALF = PW'(45) << (K - 1);
  localparam logic [MW-1:0] M_C  = MW'((64'd1 << S) / 64'd45);
  localparam longint PA_L =
    (longint'(PI_Q30) + (64'sd1 << (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
  localparam longint HA_L =
    (longint'(PI_Q30) + (64'sd1 << (30 - ANGLE_FRAC_BITS))) >>> (31 - ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] PA = AW'(PA_L);
  localparam logic signed [AW-1:0] HA = AW'(HA_L);

  logic [DEG_W-1:0]     mag;
  logic [PW-1:0]        prod;
  logic [NW-1:0]        n1_r, n2_r;
  logic                 neg1_r, neg2_r;
  logic [NW+MW-1:0]     qp;
  logic [QW-1:0]        qe_r;
  logic [NW-1:0]        rem;
  logic [QW-1:0]        q;
  logic signed [AW-1:0] ang;
  logic signed [AW-1:0] ang_red;
  logic                 flip_nxt;
  cval_t                z_r;
  logic                 flip_r;

  always_comb begin
    mag  = deg_in[DEG_W] ? DEG_W'(-deg_in) : DEG_W'(deg_in);
    prod = PW'(mag) * PW'(PI_Q30) + HALF;
  end

  assign qp = (NW+MW)'(n1_r) * (NW+MW)'(M_C);

  always_comb begin
    rem = n2_r - (NW'({qe_r, 5'b0}) + NW'({qe_r, 3'b0}) + NW'({qe_r, 2'b0}) + NW'(qe_r));
    q   = (rem >= NW'(45)) ? qe_r + QW'(1) : qe_r;
    ang = neg2_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (ang > HA) begin
      ang_red  = PA - ang;
      flip_nxt = 1'b1;
    end else if (ang < -HA) begin
      ang_red  = -PA - ang;
      flip_nxt = 1'b1;
    end else begin
      ang_red  = ang;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r   <= prod[K +: NW];
      neg1_r <= deg_in[DEG_W];
      qe_r   <= qp[S +: QW];
      n2_r   <= n1_r;
      neg2_r <= neg1_r;
      z_r    <= cval_t'(ang_red) <<< (30 - ANGLE_FRAC_BITS);
      flip_r <= flip_nxt;
    end
  end

  assign z_out    = z_r;
  assign flip_out = flip_r;

endmodule

// File: sv/hvd_rot.sv
module hvd_rot #(
  parameter int STEPS = hvd_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  hvd_pkg::cval_t z_in,
  input  logic           flip_in,
  output hvd_pkg::cval_t sin_out,
  output hvd_pkg::cval_t cos_out
);
  import hvd_pkg::*;

  cval_t            x_r [STEPS];
  cval_t            y_r [STEPS];
  cval_t            z_r [STEPS];
  logic [STEPS-1:0] f_r;
  cval_t            xs [STEPS];
  cval_t            ys [STEPS];
  cval_t            zs [STEPS];
  logic [STEPS-1:0] fs;

  always_comb begin
    xs[0] = CORDIC_K;
    ys[0] = '0;
    zs[0] = z_in;
    fs[0] = flip_in;
    for (int i = 1; i < STEPS; i++) begin
      xs[i] = x_r[i-1];
      ys[i] = y_r[i-1];
      zs[i] = z_r[i-1];
      fs[i] = f_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < STEPS; i++) begin
        if (!zs[i][DW-1]) begin
          x_r[i] <= xs[i] - (ys[i] >>> i);
          y_r[i] <= ys[i] + (xs[i] >>> i);
          z_r[i] <= zs[i] - atan_q30(5'(i));
        end else begin
          x_r[i] <= xs[i] + (ys[i] >>> i);
          y_r[i] <= ys[i] - (xs[i] >>> i);
          z_r[i] <= zs[i] + atan_q30(5'(i));
        end
        f_r[i] <= fs[i];
      end
    end
  end

  assign sin_out = y_r[STEPS-1];
  assign cos_out = f_r[STEPS-1] ? -x_r[STEPS-1] : x_r[STEPS-1];

endmodule

// File: sv/hvd_isqrt.sv
module hvd_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hvd_pkg::SQ_W-1:0]   v_in,
  output logic [hvd_pkg::ROOT_W-1:0] root_out
);
  import hvd_pkg::*;

  logic [SQ_W-1:0] v_r [SQRT_STEPS];
  logic [SQ_W-1:0] r_r [SQRT_STEPS];
  logic [SQ_W-1:0] vs  [SQRT_STEPS];
  logic [SQ_W-1:0] rs  [SQRT_STEPS];

  always_comb begin
    vs[0] = v_in;
    rs[0] = '0;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      vs[j] = v_r[j-1];
      rs[j] = r_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        if (vs[j] >= rs[j] + (SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j)))) begin
          v_r[j] <= vs[j] - (rs[j] + (SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j))));
          r_r[j] <= (rs[j] >> 1) + (SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j)));
        end else begin
          v_r[j] <= vs[j];
          r_r[j] <= rs[j] >> 1;
        end
      end
    end
  end

  assign root_out = r_r[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// File: sv/hvd_vec.sv
module hvd_vec #(
  parameter int STEPS = hvd_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  hvd_pkg::cval_t x_in,
  input  hvd_pkg::cval_t y_in,
  output hvd_pkg::cval_t z_out
);
  import hvd_pkg::*;

  cval_t x_r [STEPS];
  cval_t y_r [STEPS];
  cval_t z_r [STEPS];
  cval_t xs  [STEPS];
  cval_t ys  [STEPS];
  cval_t zs  [STEPS];

  always_comb begin
    xs[0] = x_in;
    ys[0] = y_in;
    zs[0] = '0;
    for (int i = 1; i < STEPS; i++) begin
      xs[i] = x_r[i-1];
      ys[i] = y_r[i-1];
      zs[i] = z_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < STEPS; i++) begin
        if (!ys[i][DW-1]) begin
          x_r[i] <= xs[i] + (ys[i] >>> i);
          y_r[i] <= ys[i] - (xs[i] >>> i);
          z_r[i] <= zs[i] + atan_q30(5'(i));
        end else begin
          x_r[i] <= xs[i] - (ys[i] >>> i);
          y_r[i] <= ys[i] + (xs[i] >>> i);
          z_r[i] <= zs[i] - atan_q30(5'(i));
        end
      end
    end
  end

  assign z_out = z_r[STEPS-1];

endmodule

// File: test/haversine_distance_test.sv
module haversine_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hvd_pkg::*;

  localparam longint ARC_TAB [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001,
    64'h0, 64'h0
  };
  localparam int     ROT_STEPS  = CORDIC_STEPS_DEF < 32 ? CORDIC_STEPS_DEF : 32;
  localparam int     RAD_FRAC   = ANGLE_FRAC_DEF;
  localparam longint PI_FIX     = 64'd3373259425;
  localparam longint UNIT       = 64'd1073741824;
  localparam longint QUARTER    = 64'd1686629713;
  localparam longint GAIN_START = 64'd652032874;
  localparam longint DEG_MAX    = 64'd11796480;
  localparam longint DEG_90     = 64'd5898240;

  class distance_board;
    logic [DIST_W-1:0] expected_km[$];
    int errors;

    function longint clamp_deg(deg_t v);
      longint r;
      r = longint'(v);
      if (r > DEG_MAX) r = DEG_MAX;
      if (r < -DEG_MAX) r = -DEG_MAX;
      return r;
    endfunction

    function longint deg_to_rad(longint deg, longint dv);
      longint unsigned den, m, q;
      den = longint'(dv) << (46 - RAD_FRAC);
      m = (deg < 0) ? -deg : deg;
      q = (m * PI_FIX + den / 2) / den;
      return (deg < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void rotate(longint ang, output longint s, output longint c);
      longint pa, ha, x, y, z, dx, dy;
      bit flip;
      pa = (PI_FIX + (64'd1 << (29 - RAD_FRAC))) >> (30 - RAD_FRAC);
      ha = (PI_FIX + (64'd1 << (30 - RAD_FRAC))) >> (31 - RAD_FRAC);
      flip = 0;
      x = GAIN_START;
      y = 0;
      if (ang > ha) begin
        ang = pa - ang;
        flip = 1;
      end else if (ang < -ha) begin
        ang = -pa - ang;
        flip = 1;
      end
      z = ang * (64'sd1 <<< (30 - RAD_FRAC));
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ARC_TAB[i];
        end else begin
          x += dx; y -= dy; z += ARC_TAB[i];
        end
      end
      s = y;
      c = flip ? -x : x;
    endfunction

    function longint root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function logic [DIST_W-1:0] great_circle_km(deg_t la1_i, deg_t lo1_i,
                                                deg_t la2_i, deg_t lo2_i);
      longint la1, lo1, la2, lo2, s1, s2, c1, c2, sd, cd, hav, x, y, z, dx, dy;
      la1 = clamp_deg(la1_i);
      lo1 = clamp_deg(lo1_i);
      la2 = clamp_deg(la2_i);
      lo2 = clamp_deg(lo2_i);
      rotate(deg_to_rad(la2 - la1, 360), s1, cd);
      rotate(deg_to_rad(lo2 - lo1, 360), s2, cd);
      rotate(deg_to_rad(la1, 180), sd, c1);
      rotate(deg_to_rad(la2, 180), sd, c2);
      hav = ((s1 * s1) >>> 30) + ((((s2 * s2) >>> 30) * ((c1 * c2) >>> 30)) >>> 30);
      if (hav < 0) hav = 0;
      if (hav > UNIT) hav = UNIT;
      x = root_floor(longint'(UNIT - hav) << 30);
      y = root_floor(longint'(hav) << 30);
      z = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += ARC_TAB[i];
        end else begin
          x -= dx; y += dy; z -= ARC_TAB[i];
        end
      end
      if (z < 0) z = 0;
      if (z > QUARTER) z = QUARTER;
      return DIST_W'((64'd12742 * z + (64'd1 << 21)) >> 22);
    endfunction

    function void note_request(deg_t la1, deg_t lo1, deg_t la2, deg_t lo2);
      expected_km.push_back(great_circle_km(la1, lo1, la2, lo2));
    endfunction

    function void check_result(logic [DIST_W-1:0] got);
      logic [DIST_W-1:0] want;
      if (expected_km.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = expected_km.pop_front();
        if (got !== want) begin
          $display("%0t: distance_km mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  deg_t in_from_lat = '0, in_from_lon = '0, in_to_lat = '0, in_to_lon = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [DIST_W-1:0] out_distance_km;

  distance_board board = new();
  int idle_pct = 0;
  int stall_pct = 0;

  haversine_distance u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_from_lat(in_from_lat), .in_from_lon(in_from_lon),
    .in_to_lat(in_to_lat), .in_to_lon(in_to_lon),
    .out_valid(out_valid), .out_ready(out_ready), .out_distance_km(out_distance_km)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_request(in_from_lat, in_from_lon, in_to_lat, in_to_lon);
      if (out_valid && out_ready) board.check_result(out_distance_km);
    end
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  task send_request(longint la1, longint lo1, longint la2, longint lo2);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_from_lat <= deg_t'(la1);
    in_from_lon <= deg_t'(lo1);
    in_to_lat <= deg_t'(la2);
    in_to_lon <= deg_t'(lo2);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function longint any_deg();
    return longint'($urandom_range(23592960)) - DEG_MAX;
  endfunction

  function longint raw_deg();
    return longint'(deg_t'($urandom));
  endfunction

  task send_random();
    longint la1, lo1, la2, lo2;
    int pick;
    pick = $urandom_range(99);
    la1 = any_deg();
    lo1 = any_deg();
    if (pick < 55) begin
      la1 = longint'($urandom_range(11796480)) - DEG_90;
      la2 = longint'($urandom_range(11796480)) - DEG_90;
      lo2 = any_deg();
    end else if (pick < 75) begin
      la2 = la1 + longint'($urandom_range(2000000)) - 1000000;
      lo2 = lo1 + longint'($urandom_range(2000000)) - 1000000;
      if (la2 > DEG_MAX) la2 = DEG_MAX;
      if (la2 < -DEG_MAX) la2 = -DEG_MAX;
      if (lo2 > DEG_MAX) lo2 = DEG_MAX;
      if (lo2 < -DEG_MAX) lo2 = -DEG_MAX;
    end else if (pick < 85) begin
      la2 = any_deg();
      lo2 = any_deg();
    end else begin
      la1 = raw_deg();
      lo1 = raw_deg();
      la2 = raw_deg();
      lo2 = raw_deg();
    end
    send_request(la1, lo1, la2, lo2);
  endtask

  task drain();
    in_valid <= 0;
    while (board.expected_km.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_request(0, 0, 0, 0);
    send_request(DEG_90, 0, -DEG_90, 0);
    send_request(0, 0, 0, DEG_MAX);
    send_request(0, -DEG_MAX, 0, DEG_MAX);
    send_request(-DEG_MAX, -DEG_MAX, DEG_MAX, DEG_MAX);
    send_request(DEG_MAX, DEG_MAX, DEG_MAX, DEG_MAX);
    send_request(64'sd16777215, 64'sd16777215, -64'sd16777216, -64'sd16777216);
    send_request(-64'sd16777216, 0, 64'sd16777215, 0);
    send_request(DEG_MAX + 1, 0, -DEG_MAX - 1, 1);
    send_request(7864320, 0, -7864320, 0);
    send_request(DEG_90, DEG_MAX, DEG_90 - 1, -DEG_MAX);
    send_request(0, 0, 1, 1);
    send_request(-1, -1, 0, 0);
    send_request(DEG_90, 0, DEG_90, DEG_MAX);
    send_request(2621440, 11141120, -2621440, -655360);
    send_request(10000000, 3000000, -10000000, -3000000);
    send_request(0, 0, 0, DEG_90);
    send_request(-DEG_90, DEG_90, DEG_90, -DEG_90);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 54 : 20) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 54 : 20) : 0;
      for (int n = 0; n < 400; n++) begin
        send_random();
        if (n == 200) drain();
      end
    end
    drain();
    idle_pct = 0;
    stall_pct = 0;
    repeat (120) @(posedge clk);
    if (board.errors == 0 && board.expected_km.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
